// File: design/sraq_pkg.sv
// Shared types and constants for the reserved-slot admission queue.
// No dependencies; imported by the admission logic and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sraq_pkg;

  // Field widths fixed by the descriptor format
  localparam int CountW = 5;
  localparam int ByteW  = 32;
  localparam int MsgW   = 16;

  // Each message carries a 4-byte frame prefix: cost adds count << 2
  localparam int FramePrefixShift = 2;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_ITEMS     = 2'd0;
  localparam logic [1:0] CFG_MAX_BYTES     = 2'd1;
  localparam logic [1:0] CFG_RESERVE_BYTES = 2'd2;

  typedef enum logic [1:0] {
    MODE_REGULAR  = 2'd0,
    MODE_TERMINAL = 2'd1,
    MODE_POP      = 2'd2,
    MODE_CLOSE    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED     = 3'd0,
    ST_CLOSED       = 3'd1,
    ST_TERM_PENDING = 3'd2,
    ST_COUNT_FULL   = 3'd3,
    ST_BYTES_FULL   = 3'd4,
    ST_POPPED       = 3'd5,
    ST_EMPTY        = 3'd6
  } status_e;

  // Limits from the configuration registers
  typedef struct packed {
    logic [CountW-1:0] max_items;
    logic [ByteW-1:0]  max_bytes;
    logic [ByteW-1:0]  reserve_bytes;
  } cfg_t;

  // Queue occupancy seen by admission
  typedef struct packed {
    logic [CountW-1:0] fill;
    logic [ByteW-1:0]  total_bytes;
    logic              closed;
    logic              terminal;
  } qstate_t;

  // Admission decision for one enqueue item
  typedef struct packed {
    status_e          status;
    logic             push;
    logic [ByteW-1:0] cost;
  } admit_t;

endpackage

`default_nettype wire

// File: design/sraq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; a read in the same cycle as a write to that address returns old data.
`timescale 1ns / 1ps
`default_nettype none

module sraq_ram #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/sraq_admit.sv
// Admission check for one enqueue item: framed cost, refusal order and limits.
// Depends on sraq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sraq_admit
  import sraq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire mode_e                  mode_i,
  input  wire logic [ByteW-1:0]       payload_bytes_i,
  input  wire logic [MsgW-1:0]        message_count_i,
  input  wire cfg_t                   cfg_i,
  input  wire qstate_t                state_i,
  output admit_t                      admit_o
);

  // Largest count limit the storage allows (the count register tops out at 31)
  localparam int                CapMax  = (DEPTH < 31) ? DEPTH : 31;
  localparam logic [CountW-1:0] CapMaxW = CountW'(CapMax);

  logic [ByteW:0]    cost_w;
  logic              terminal;
  logic [CountW-1:0] cap;
  logic [CountW-1:0] slot_limit;
  logic [ByteW-1:0]  regular_limit;
  logic [ByteW-1:0]  room_limit;
  logic [ByteW:0]    total_after;

  // Framed cost: payload plus a prefix per message; bit 32 flags overflow
  assign cost_w = {1'b0, payload_bytes_i}
                + {{(ByteW + 1 - MsgW - FramePrefixShift){1'b0}}, message_count_i,
                   {FramePrefixShift{1'b0}}};

  assign terminal = (mode_i == MODE_TERMINAL);

  // Count limit: a regular batch leaves one slot for the terminal batch
  assign cap        = (cfg_i.max_items > CapMaxW) ? CapMaxW : cfg_i.max_items;
  assign slot_limit = terminal ? cap : ((cap == '0) ? '0 : cap - 1'b1);

  // Byte limit: a regular batch leaves the reserve free
  assign regular_limit = (cfg_i.max_bytes >= cfg_i.reserve_bytes) ?
                         cfg_i.max_bytes - cfg_i.reserve_bytes : '0;
  assign room_limit    = terminal ? cfg_i.max_bytes : regular_limit;
  assign total_after   = {1'b0, state_i.total_bytes} + {1'b0, cost_w[ByteW-1:0]};

  // Refusals in priority order
  always_comb begin
    admit_o.cost   = cost_w[ByteW-1:0];
    admit_o.push   = 1'b0;
    admit_o.status = ST_ACCEPTED;
    priority if (cost_w[ByteW]) begin
      admit_o.status = ST_BYTES_FULL;
    end else if (!terminal && message_count_i == '0) begin
      // empty regular batch: acknowledge, store nothing
      admit_o.status = ST_ACCEPTED;
    end else if (state_i.closed) begin
      admit_o.status = ST_CLOSED;
    end else if (state_i.terminal) begin
      admit_o.status = ST_TERM_PENDING;
    end else if (state_i.fill >= slot_limit) begin
      admit_o.status = ST_COUNT_FULL;
    end else if (total_after > {1'b0, room_limit}) begin
      admit_o.status = ST_BYTES_FULL;
    end else begin
      admit_o.status = ST_ACCEPTED;
      admit_o.push   = 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: design/reserved_slot_admission_queue.sv
// Top level of the reserved-slot admission queue: command port, descriptor FIFO, results.
// Depends on sraq_pkg, sraq_admit and sraq_ram.
`timescale 1ns / 1ps
`default_nettype none

// One command item is taken on every clock in which start_i is high; busy_o
// never rises. Each item gives one result, shown with done_o for a single
// cycle: the item passes through the input register, then one pass through
// the admission check and FIFO bookkeeping, then the result register. Items
// may follow back to back and the receiver cannot stall. Descriptors sit in
// a RAM with a registered read; the head entry is fetched ahead from the
// updated head pointer and a write to the head address is bypassed. No
// clearing pass follows reset. Write configuration only while no item is in flight.

module reserved_slot_admission_queue
  import sraq_pkg::*;
#(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Command channel
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic [1:0]          mode_i,
  input  wire logic [ByteW-1:0]    payload_bytes_i,
  input  wire logic [MsgW-1:0]     message_count_i,
  input  wire logic [TAG_BITS-1:0] batch_tag_i,
  // Configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [ByteW-1:0]    cfg_wdata_i,
  // Result channel
  output logic                     done_o,
  output logic [2:0]               status_o,
  output logic [TAG_BITS-1:0]      popped_tag_o,
  output logic [ByteW-1:0]         popped_bytes_o,
  output logic                     popped_terminal_o,
  output logic                     is_closed_o,
  output logic [CountW-1:0]        queued_count_o,
  output logic [ByteW-1:0]         queued_total_bytes_o
);

  localparam int              PtrW    = $clog2(DEPTH);
  localparam int              EntryW  = 1 + ByteW + TAG_BITS;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == LastPtr) ? '0 : p + 1'b1;
  endfunction

  // Configuration
  cfg_t cfg_q;

  // Input register
  logic                in_valid_q;
  mode_e               mode_q;
  logic [ByteW-1:0]    payload_q;
  logic [MsgW-1:0]     count_q;
  logic [TAG_BITS-1:0] tag_q;

  // Queue state
  logic [PtrW-1:0]   head_q, head_d;
  logic [PtrW-1:0]   tail_q, tail_d;
  logic [CountW-1:0] fill_q, fill_d;
  logic [ByteW-1:0]  total_q, total_d;
  logic              closed_q, closed_d;
  logic              term_q, term_d;

  // Head read bypass
  logic              byp_q, byp_d;
  logic [EntryW-1:0] byp_data_q;

  // Result register
  logic                done_q;
  status_e             status_q, status_d;
  logic [TAG_BITS-1:0] ptag_q, ptag_d;
  logic [ByteW-1:0]    pbytes_q, pbytes_d;
  logic                pterm_q, pterm_d;

  qstate_t             qstate;
  admit_t              adm;
  logic                push;
  logic [EntryW-1:0]   wdata;
  logic [EntryW-1:0]   ram_rdata;
  logic [EntryW-1:0]   head_data;

  assign busy_o = 1'b0;

  // Write configuration registers; other indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_items     <= CountW'(16);
      cfg_q.max_bytes     <= ByteW'(65536);
      cfg_q.reserve_bytes <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MAX_ITEMS) begin
        cfg_q.max_items <= cfg_wdata_i[CountW-1:0];
      end
      if (cfg_idx_i == CFG_MAX_BYTES) begin
        cfg_q.max_bytes <= cfg_wdata_i;
      end
      if (cfg_idx_i == CFG_RESERVE_BYTES) begin
        cfg_q.reserve_bytes <= cfg_wdata_i;
      end
    end
  end

  // Capture the command item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mode_q    <= mode_e'(mode_i);
      payload_q <= payload_bytes_i;
      count_q   <= message_count_i;
      tag_q     <= batch_tag_i;
    end
  end

  assign qstate.fill        = fill_q;
  assign qstate.total_bytes = total_q;
  assign qstate.closed      = closed_q;
  assign qstate.terminal    = term_q;

  sraq_admit #(
    .DEPTH(DEPTH)
  ) u_admit (
    .mode_i         (mode_q),
    .payload_bytes_i(payload_q),
    .message_count_i(count_q),
    .cfg_i          (cfg_q),
    .state_i        (qstate),
    .admit_o        (adm)
  );

  // Head entry: bypass when the head slot was written last cycle
  assign head_data = byp_q ? byp_data_q : ram_rdata;

  // Apply the item to the queue and form its result
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    total_d  = total_q;
    closed_d = closed_q;
    term_d   = term_q;
    status_d = ST_ACCEPTED;
    ptag_d   = '0;
    pbytes_d = '0;
    pterm_d  = 1'b0;
    push     = 1'b0;
    if (in_valid_q) begin
      unique case (mode_q)
        MODE_REGULAR, MODE_TERMINAL: begin
          status_d = adm.status;
          if (adm.push) begin
            push    = 1'b1;
            tail_d  = ptr_inc(tail_q);
            fill_d  = fill_q + 1'b1;
            total_d = total_q + adm.cost;
            term_d  = (mode_q == MODE_TERMINAL);
          end
        end
        MODE_POP: begin
          if (fill_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            status_d = ST_POPPED;
            ptag_d   = head_data[TAG_BITS-1:0];
            pbytes_d = head_data[TAG_BITS +: ByteW];
            pterm_d  = head_data[EntryW-1];
            total_d  = total_q - head_data[TAG_BITS +: ByteW];
            head_d   = ptr_inc(head_q);
            fill_d   = fill_q - 1'b1;
          end
        end
        MODE_CLOSE: begin
          closed_d = 1'b1;
        end
        default: begin
          status_d = ST_ACCEPTED;
        end
      endcase
    end
  end

  assign wdata = {(mode_q == MODE_TERMINAL), adm.cost, tag_q};
  assign byp_d = push && (tail_q == head_d);

  sraq_ram #(
    .WIDTH(EntryW),
    .DEPTH(DEPTH)
  ) u_desc_ram (
    .clk_i  (clk_i),
    .we_i   (push),
    .waddr_i(tail_q),
    .wdata_i(wdata),
    .raddr_i(head_d),
    .rdata_o(ram_rdata)
  );

  // Advance queue state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      fill_q   <= '0;
      total_q  <= '0;
      closed_q <= 1'b0;
      term_q   <= 1'b0;
      byp_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      fill_q   <= fill_d;
      total_q  <= total_d;
      closed_q <= closed_d;
      term_q   <= term_d;
      byp_q    <= byp_d;
      done_q   <= in_valid_q;
    end
  end

  // Hold the result payload and the bypassed head entry
  always_ff @(posedge clk_i) begin
    byp_data_q <= wdata;
    status_q   <= status_d;
    ptag_q     <= ptag_d;
    pbytes_q   <= pbytes_d;
    pterm_q    <= pterm_d;
  end

  assign done_o               = done_q;
  assign status_o             = status_q;
  assign popped_tag_o         = ptag_q;
  assign popped_bytes_o       = pbytes_q;
  assign popped_terminal_o    = pterm_q;
  assign is_closed_o          = closed_q;
  assign queued_count_o       = fill_q;
  assign queued_total_bytes_o = total_q;

endmodule

`default_nettype wire
